// File: rtl/core/bsl_pkg.sv
// Shared types, constants and byte classification functions of the byte stream lexer.
package bsl_pkg;

  localparam int unsigned MAX_LEXEME_DEF = 79;
  localparam int unsigned POS_WIDTH_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned KW_COUNT       = 3;
  localparam int unsigned KW_MAX_CHARS   = 5;

  localparam int unsigned KW_IF    = 0;
  localparam int unsigned KW_WHILE = 1;
  localparam int unsigned KW_ELSE  = 2;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] pos_out_t;
  typedef logic [6:0]  len_t;
  typedef logic [KW_COUNT-1:0] kw_set_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    TK_NUM       = 4'd0,
    TK_NUM_ERROR = 4'd1,
    TK_IDENT     = 4'd2,
    TK_IF        = 4'd3,
    TK_WHILE     = 4'd4,
    TK_ELSE      = 4'd5,
    TK_ASSIGN    = 4'd6,
    TK_PLUS      = 4'd7,
    TK_MINUS     = 4'd8,
    TK_TIMES     = 4'd9,
    TK_DIV       = 4'd10,
    TK_SEMICOLON = 4'd11,
    TK_GREATER   = 4'd12,
    TK_UNKNOWN   = 4'd13
  } token_kind_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_OP,
    CLS_OTHER
  } byte_class_t;

  localparam byte_t KW_TEXT [KW_COUNT][KW_MAX_CHARS] = '{
    '{"I", "F", 8'h00, 8'h00, 8'h00},
    '{"W", "H", "I", "L", "E"},
    '{"E", "L", "S", "E", 8'h00}
  };
  localparam len_t KW_LEN [KW_COUNT] = '{7'd2, 7'd5, 7'd4};

  typedef struct packed {
    byte_t ch;
    logic  end_of_text;
  } in_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    pos_out_t    start_pos;
    len_t        lexeme_len;
    logic        too_long;
    logic        last;
  } out_item_t;

  typedef struct packed {
    token_kind_t kind;
    pos_out_t    start;
    len_t        len;
    logic        too_long;
  } tok_t;

  // One queue entry carries every token caused by one byte.
  typedef struct packed {
    logic pair;
    tok_t tok_a;
    tok_t tok_b;
  } q_entry_t;

  function automatic token_kind_t op_kind(input byte_t c);
    token_kind_t k;
    unique case (c)
      "=":     k = TK_ASSIGN;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_TIMES;
      "/":     k = TK_DIV;
      ";":     k = TK_SEMICOLON;
      ">":     k = TK_GREATER;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic byte_class_t classify(input byte_t c);
    byte_class_t cls;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      cls = CLS_SPACE;
    end else if (c >= "0" && c <= "9") begin
      cls = CLS_DIGIT;
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      cls = CLS_ALPHA;
    end else if (op_kind(c) != TK_UNKNOWN) begin
      cls = CLS_OP;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // Keep the keywords that still match after byte c at position idx.
  function automatic kw_set_t kw_match(input kw_set_t cand, input len_t idx, input byte_t c);
    kw_set_t res;
    res = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand[k] && idx < KW_LEN[k] && KW_TEXT[k][idx[2:0]] == c) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/bsl_front.sv
// Front end: classifies each byte, tracks the pending lexeme and forms tokens.
module bsl_front #(
  parameter int unsigned MAX_LEXEME = bsl_pkg::MAX_LEXEME_DEF,
  parameter int unsigned POS_WIDTH  = bsl_pkg::POS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  bsl_pkg::in_item_t item,
  output logic              q_push,
  output bsl_pkg::q_entry_t q_entry
);

  bsl_pkg::scan_mode_t  mode, mode_next;
  logic [POS_WIDTH-1:0] token_start, token_start_next;
  bsl_pkg::len_t        token_length, token_length_next;
  logic                 length_overflow, length_overflow_next;
  logic [POS_WIDTH-1:0] byte_position, byte_position_next;
  bsl_pkg::kw_set_t     cand, cand_next;

  bsl_pkg::byte_class_t cls;
  bsl_pkg::tok_t        close_tok, pend_tok, new_tok;
  logic                 pend_v, new_v;
  logic                 can_grow;

  assign cls      = bsl_pkg::classify(item.ch);
  assign can_grow = token_length < bsl_pkg::len_t'(MAX_LEXEME);

  // Token for the pending lexeme if it closes now.
  always_comb begin
    close_tok.start    = bsl_pkg::pos_out_t'(token_start);
    close_tok.len      = token_length;
    close_tok.too_long = length_overflow;
    close_tok.kind     = bsl_pkg::TK_IDENT;
    if (mode == bsl_pkg::MODE_NUM) begin
      close_tok.kind = bsl_pkg::TK_NUM;
    end else if (!length_overflow) begin
      if (cand[bsl_pkg::KW_IF] && token_length == bsl_pkg::KW_LEN[bsl_pkg::KW_IF]) begin
        close_tok.kind = bsl_pkg::TK_IF;
      end else if (cand[bsl_pkg::KW_WHILE] &&
                   token_length == bsl_pkg::KW_LEN[bsl_pkg::KW_WHILE]) begin
        close_tok.kind = bsl_pkg::TK_WHILE;
      end else if (cand[bsl_pkg::KW_ELSE] &&
                   token_length == bsl_pkg::KW_LEN[bsl_pkg::KW_ELSE]) begin
        close_tok.kind = bsl_pkg::TK_ELSE;
      end
    end
  end

  // Next scan mode.
  always_comb begin
    mode_next = mode;
    if (accept) begin
      if (item.end_of_text) begin
        mode_next = bsl_pkg::MODE_IDLE;
      end else begin
        unique case (cls)
          bsl_pkg::CLS_DIGIT: mode_next = (mode == bsl_pkg::MODE_IDLE) ? bsl_pkg::MODE_NUM : mode;
          bsl_pkg::CLS_ALPHA: mode_next = bsl_pkg::MODE_IDENT;
          default:            mode_next = bsl_pkg::MODE_IDLE;
        endcase
      end
    end
  end

  // Lexeme bookkeeping and token outputs.
  always_comb begin
    token_start_next     = token_start;
    token_length_next    = token_length;
    length_overflow_next = length_overflow;
    byte_position_next   = byte_position;
    cand_next            = cand;
    pend_v               = 1'b0;
    pend_tok             = close_tok;
    new_v                = 1'b0;
    new_tok.kind         = bsl_pkg::op_kind(item.ch);
    new_tok.start        = bsl_pkg::pos_out_t'(byte_position);
    new_tok.len          = bsl_pkg::len_t'(1);
    new_tok.too_long     = 1'b0;
    if (accept) begin
      if (item.end_of_text) begin
        pend_v             = (mode == bsl_pkg::MODE_NUM) || (mode == bsl_pkg::MODE_IDENT);
        byte_position_next = '0;
      end else begin
        byte_position_next = byte_position + POS_WIDTH'(1);
        if ((mode == bsl_pkg::MODE_NUM && cls == bsl_pkg::CLS_DIGIT) ||
            (mode == bsl_pkg::MODE_IDENT &&
             (cls == bsl_pkg::CLS_DIGIT || cls == bsl_pkg::CLS_ALPHA))) begin
          // Extend the pending lexeme, saturating its length.
          if (can_grow) begin
            cand_next         = bsl_pkg::kw_match(cand, token_length, item.ch);
            token_length_next = token_length + bsl_pkg::len_t'(1);
          end else begin
            length_overflow_next = 1'b1;
            cand_next            = '0;
          end
        end else begin
          // Close whatever is pending, then treat the byte as if idle.
          if (mode == bsl_pkg::MODE_NUM || mode == bsl_pkg::MODE_IDENT) begin
            pend_v = 1'b1;
          end
          if (mode == bsl_pkg::MODE_NUM && cls == bsl_pkg::CLS_ALPHA) begin
            pend_tok.kind = bsl_pkg::TK_NUM_ERROR;
          end
          case (cls)
            bsl_pkg::CLS_DIGIT, bsl_pkg::CLS_ALPHA: begin
              token_start_next     = byte_position;
              token_length_next    = bsl_pkg::len_t'(1);
              length_overflow_next = 1'b0;
              cand_next = bsl_pkg::kw_match('1, bsl_pkg::len_t'(0), item.ch);
            end
            bsl_pkg::CLS_SPACE: new_v = 1'b0;
            default:            new_v = 1'b1;
          endcase
        end
      end
    end
  end

  always_comb begin
    q_push        = pend_v || new_v;
    q_entry.pair  = pend_v && new_v;
    q_entry.tok_a = pend_v ? pend_tok : new_tok;
    q_entry.tok_b = new_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= bsl_pkg::MODE_IDLE;
      token_start     <= '0;
      token_length    <= '0;
      length_overflow <= 1'b0;
      byte_position   <= '0;
      cand            <= '0;
    end else begin
      mode            <= mode_next;
      token_start     <= token_start_next;
      token_length    <= token_length_next;
      length_overflow <= length_overflow_next;
      byte_position   <= byte_position_next;
      cand            <= cand_next;
    end
  end

endmodule

// File: rtl/core/bsl_queue.sv
// Short queue of token groups between the front end and the result stage.
module bsl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  bsl_pkg::q_entry_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              nonempty,
  output bsl_pkg::q_entry_t rd_data
);

  localparam int unsigned PTR_W = $clog2(bsl_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(bsl_pkg::QUEUE_DEPTH + 1);

  bsl_pkg::q_entry_t mem [bsl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr, do_rd;

  assign full     = count == CNT_W'(bsl_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/bsl_back.sv
// Result stage: splits token groups into single results in an output register.
module bsl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  bsl_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output bsl_pkg::out_item_t result
);

  logic          out_valid;
  logic          on_second, on_second_next;
  logic          load, final_tok;
  bsl_pkg::tok_t sel;

  assign load      = q_nonempty && (!out_valid || pop);
  assign final_tok = !q_head.pair || on_second;
  assign sel       = on_second ? q_head.tok_b : q_head.tok_a;
  assign q_pop     = load && final_tok;
  assign empty     = !out_valid;

  always_comb begin
    on_second_next = on_second;
    if (load) begin
      on_second_next = !final_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.token_kind <= sel.kind;
      result.start_pos  <= sel.start;
      result.lexeme_len <= sel.len;
      result.too_long   <= sel.too_long;
      result.last       <= final_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      on_second <= 1'b0;
    end else begin
      on_second <= on_second_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/byte_stream_lexer.sv
// Byte stream lexer: one byte per cycle in while the queue has room, tokens out through a queue interface.
// Throughput: one byte accepted per cycle while the queue has room, one result delivered per cycle while popped.
// A token formed from an accepted byte goes into the token queue, then into the result register once it is free.
// A byte that closes a token and forms another gives two results, delivered one after the other;
// the two-entry token queue holds these, but input waits whenever both entries are taken.
// Reset (rst, synchronous): clears scan mode, lexeme state, position, queue and output valid flag.
module byte_stream_lexer #(
  parameter int unsigned MAX_LEXEME = bsl_pkg::MAX_LEXEME_DEF,
  parameter int unsigned POS_WIDTH  = bsl_pkg::POS_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  bsl_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output bsl_pkg::out_item_t result
);

  logic              accept;
  logic              q_push, q_pop, q_nonempty;
  bsl_pkg::q_entry_t q_entry, q_head;

  // Take a byte whenever the queue has room; a byte with no token still waits for room.
  assign accept = push && !full;

  // Front end: classify the byte, advance the lexeme, form up to two tokens.
  bsl_front #(
    .MAX_LEXEME(MAX_LEXEME),
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  // Hold token groups so each side can stall on its own.
  bsl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_entry),
    .full    (full),
    .rd_en   (q_pop),
    .nonempty(q_nonempty),
    .rd_data (q_head)
  );

  // Back end: drop groups into the output register one token per transaction.
  bsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nonempty(q_nonempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
